// ----- rtl/pnsr_pkg.sv -----
// shared types, codes and raster function for the packed nibble span raster engine
package pnsr_pkg;

   localparam int ROW_W = 8;
   localparam int COL_W = 9;
   localparam int BYTE_IDX_W = COL_W - 1;
   localparam int MAX_ROWS = 1 << ROW_W;

   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

   localparam logic [7:0] NIB_HI_MASK = 8'hF0;
   localparam logic [7:0] NIB_LO_MASK = 8'h0F;

   localparam logic KIND_PAINT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [2:0] {
      MODE_SET    = 3'd0,
      MODE_OR     = 3'd1,
      MODE_ORNOT  = 3'd2,
      MODE_AND    = 3'd3,
      MODE_ANDNOT = 3'd4,
      MODE_XOR    = 3'd5,
      MODE_INVERT = 3'd6,
      MODE_NOOP   = 3'd7
   } raster_mode_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_PAINT = 2'd1,
      OP_READ  = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type            op;
      logic                  was_read;
      logic [ROW_W-1:0]      row;
      logic [BYTE_IDX_W-1:0] byte_first;
      logic [BYTE_IDX_W-1:0] byte_last;
      logic [1:0]            mask_first;  // {high nibble, low nibble}
      logic [1:0]            mask_last;
      logic                  nib_lo;
      logic [3:0]            color;
      raster_mode_type       mode;
   } pnsr_cmd_type;

   function automatic logic [3:0] raster_nib(raster_mode_type m, logic [3:0] old,
                                             logic [3:0] c);
      logic [3:0] r;
      case (m)
         MODE_SET:    r = c;
         MODE_OR:     r = old | c;
         MODE_ORNOT:  r = old | ~c;
         MODE_AND:    r = old & c;
         MODE_ANDNOT: r = old & ~c;
         MODE_XOR:    r = old ^ c;
         MODE_INVERT: r = old ^ NIB_LO_MASK[3:0];
         default:     r = old;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/pnsr_channels.sv -----
// valid/ready channel interfaces for paint/read requests and responses
interface pnsr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] row;
   logic [8:0] x_first;
   logic [8:0] x_last;
   logic [3:0] color;
   logic [2:0] mode;

   modport source (output valid, kind, row, x_first, x_last, color, mode, input ready);
   modport sink   (input valid, kind, row, x_first, x_last, color, mode, output ready);
endinterface

interface pnsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] pixel;
   logic       was_read;

   modport source (output valid, pixel, was_read, input ready);
   modport sink   (input valid, pixel, was_read, output ready);
endinterface

// ----- rtl/pnsr_front.sv -----
// request front end: accepts beats, clips spans and builds byte-level commands
module pnsr_front #(
   parameter int FRAME_WIDTH,
   parameter int FRAME_HEIGHT
) (
   pnsr_req_if.sink              req,
   input  logic                  clear_busy,
   input  logic                  q_full,
   output logic                  push,
   output pnsr_pkg::pnsr_cmd_type cmd
);
   import pnsr_pkg::*;

   localparam logic [31:0] LAST_COL  = 32'(FRAME_WIDTH - 1);
   localparam logic [31:0] COL_LIMIT = 32'(FRAME_WIDTH);
   localparam logic [31:0] ROW_LIMIT = 32'(FRAME_HEIGHT);

   logic             row_ok;
   logic [COL_W-1:0] x_clip;
   logic             paint_ok;

   assign req.ready = !q_full && !clear_busy;
   assign push      = req.valid && req.ready;

   always_comb begin
      row_ok = 32'(req.row) < ROW_LIMIT;
      // columns past the right edge are dropped
      x_clip = (32'(req.x_last) > LAST_COL) ? LAST_COL[COL_W-1:0] : req.x_last;
      paint_ok = row_ok && (req.x_first <= req.x_last) && (req.x_first <= x_clip)
                 && (raster_mode_type'(req.mode) != MODE_NOOP);

      cmd.row        = req.row;
      cmd.byte_first = req.x_first[COL_W-1:1];
      cmd.byte_last  = x_clip[COL_W-1:1];
      cmd.mask_first = {~req.x_first[0], 1'b1};
      cmd.mask_last  = {1'b1, x_clip[0]};
      cmd.nib_lo     = req.x_first[0];
      cmd.color      = req.color;
      cmd.mode       = raster_mode_type'(req.mode);
      if (req.kind == KIND_READ) begin
         cmd.was_read = 1'b1;
         cmd.op = (row_ok && (32'(req.x_first) < COL_LIMIT)) ? OP_READ : OP_NONE;
      end else begin
         cmd.was_read = 1'b0;
         cmd.op = paint_ok ? OP_PAINT : OP_NONE;
      end
   end

endmodule

// ----- rtl/pnsr_queue.sv -----
// small command queue between front end and span engine
module pnsr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pnsr_pkg::pnsr_cmd_type din,
   output logic                   full,
   input  logic                   pop,
   output pnsr_pkg::pnsr_cmd_type dout,
   output logic                   empty
);
   import pnsr_pkg::*;

   pnsr_cmd_type           slots [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   cnt_ff, cnt_in;

   assign full  = cnt_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign dout  = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- rtl/pnsr_engine.sv -----
// span engine: frame store, clearing pass, byte read-modify-write and response register
module pnsr_engine #(
   parameter int FRAME_WIDTH,
   parameter int FRAME_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  pnsr_pkg::pnsr_cmd_type head,
   output logic                   pop,
   output logic                   clear_busy,
   pnsr_rsp_if.source             rsp
);
   import pnsr_pkg::*;

   localparam int ROW_BYTES   = (FRAME_WIDTH + 1) / 2;
   localparam int ROWS_USED   = (FRAME_HEIGHT < MAX_ROWS) ? FRAME_HEIGHT : MAX_ROWS;
   localparam int STORE_DEPTH = ROW_BYTES * ROWS_USED;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_BYTES_A = ADDR_W'(ROW_BYTES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_READ,
      ST_FETCH,
      ST_DONE
   } state_type;

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rdata_ff;

   state_type             state_ff, state_in;
   pnsr_cmd_type          cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [BYTE_IDX_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic                  wr_vld_ff, wr_vld_in;
   logic [ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   logic [1:0]            wr_mask_ff, wr_mask_in;
   logic [3:0]            pix_ff, pix_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [3:0]            rsp_pix_ff, rsp_pix_in;
   logic                  rsp_rd_ff, rsp_rd_in;

   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [3:0]        new_hi;
   logic [3:0]        new_lo;
   logic [1:0]        byte_mask;

   assign clear_busy   = state_ff == ST_CLEAR;
   assign rsp.valid    = rsp_vld_ff;
   assign rsp.pixel    = rsp_pix_ff;
   assign rsp.was_read = rsp_rd_ff;

   assign rd_addr = base_ff + ADDR_W'(cur_ff);

   always_comb begin
      new_hi = raster_nib(cmd_ff.mode, rdata_ff[7:4], cmd_ff.color);
      new_lo = raster_nib(cmd_ff.mode, rdata_ff[3:0], cmd_ff.color);
      mem_we = clear_busy || wr_vld_ff;
      if (clear_busy) begin
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_waddr = wr_addr_ff;
         mem_wdata = ((wr_mask_ff[1] ? {new_hi, 4'h0} : rdata_ff) & NIB_HI_MASK)
                   | ((wr_mask_ff[0] ? {4'h0, new_lo} : rdata_ff) & NIB_LO_MASK);
      end

      // partial nibbles at the ends of the span
      byte_mask = 2'b11;
      if (cur_ff == cmd_ff.byte_first) begin
         byte_mask = byte_mask & cmd_ff.mask_first;
      end
      if (cur_ff == cmd_ff.byte_last) begin
         byte_mask = byte_mask & cmd_ff.mask_last;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      base_in    = base_ff;
      cur_in     = cur_ff;
      clr_in     = clr_ff;
      wr_vld_in  = 1'b0;
      wr_addr_in = wr_addr_ff;
      wr_mask_in = wr_mask_ff;
      pix_in     = pix_ff;
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      rsp_pix_in = rsp_pix_ff;
      rsp_rd_in  = rsp_rd_ff;
      pop        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               cmd_in  = head;
               base_in = ADDR_W'(ADDR_W'(head.row) * ROW_BYTES_A);
               cur_in  = head.byte_first;
               pix_in  = '0;
               unique case (head.op)
                  OP_PAINT: state_in = ST_RUN;
                  OP_READ:  state_in = ST_READ;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_RUN: begin
            // read this byte now, write it back next cycle
            wr_vld_in  = 1'b1;
            wr_addr_in = rd_addr;
            wr_mask_in = byte_mask;
            cur_in     = cur_ff + 1'b1;
            if (cur_ff == cmd_ff.byte_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            pix_in   = cmd_ff.nib_lo ? rdata_ff[3:0] : rdata_ff[7:4];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp.ready) begin
               rsp_vld_in = 1'b1;
               rsp_pix_in = pix_ff;
               rsp_rd_in  = cmd_ff.was_read;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         wr_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         wr_vld_ff  <= wr_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cmd_ff     <= cmd_in;
      base_ff    <= base_in;
      cur_ff     <= cur_in;
      wr_addr_ff <= wr_addr_in;
      wr_mask_ff <= wr_mask_in;
      pix_ff     <= pix_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_rd_ff  <= rsp_rd_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

endmodule

// ----- rtl/packed_nibble_span_raster_op.sv -----
// top level: 4bpp span raster engine, front end, command queue and span engine
// paint of a span: the span engine reads and writes back one byte per cycle
// read: the span engine passes through ST_READ, ST_FETCH and ST_DONE; the result is offered from a response register
// front end takes a beat per cycle while the 4-entry command queue has room and no clearing pass runs
// after reset the store, ((FRAME_WIDTH+1)/2)*min(FRAME_HEIGHT,256) bytes (65536 at default
// size), is zeroed one byte a cycle, with req_bus.ready low throughout
module packed_nibble_span_raster_op #(
   parameter int FRAME_WIDTH  = 512,
   parameter int FRAME_HEIGHT = 256
) (
   input logic        clock,
   input logic        reset,
   pnsr_req_if.sink   req_bus,
   pnsr_rsp_if.source rsp_bus
);
   import pnsr_pkg::*;

   pnsr_cmd_type push_cmd;
   pnsr_cmd_type head_cmd;
   logic         push;
   logic         pop;
   logic         q_full;
   logic         q_empty;
   logic         clear_busy;

   pnsr_front #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_front (
      .req        (req_bus),
      .clear_busy (clear_busy),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   pnsr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (push_cmd),
      .full  (q_full),
      .pop   (pop),
      .dout  (head_cmd),
      .empty (q_empty)
   );

   pnsr_engine #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (head_cmd),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp        (rsp_bus)
   );

endmodule
